// ===== rtl/ebma_pkg.sv =====
package ebma_pkg;

  localparam int SAMPLE_W = 16;
  localparam int WIN_DEPTH = 8;
  localparam int WIN_SHIFT = $clog2(WIN_DEPTH);
  localparam int SUM_W = SAMPLE_W + WIN_SHIFT;

  // The scaled mode works on mean + 5.0 in Q13.4, one bit wider than a sample.
  localparam int SCALED_W = SAMPLE_W + 1;
  localparam logic signed [SCALED_W-1:0] FIVE_Q4 = SCALED_W'(80);

  // Division by ten: multiply by ceil(2^19 / 10) and shift right by 19.
  // The result is exact for magnitudes up to 2^17.
  localparam int RECIP_SHIFT = 19;
  localparam logic [SAMPLE_W-1:0] RECIP_TEN = SAMPLE_W'(52429);
  localparam int PROD_W = 2 * SAMPLE_W;

  localparam int OUT_FIFO_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_FIFO_DEPTH);
  localparam int OCC_W = $clog2(OUT_FIFO_DEPTH + 1);

  localparam logic signed [SAMPLE_W-1:0] THRESH_RESET = SAMPLE_W'(16000);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = SAMPLE_W;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [WIN_SHIFT-1:0] slot_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ERR_THRESH = 2'd0,
    CFG_SCALE_MODE = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    sample_t filtered;
    logic    error_pass;
  } result_t;

  // Handshake between the pipeline and the output queue.
  typedef struct packed {
    logic    wr_en;
    logic    rd_en;
  } fifo_ctrl_t;

endpackage

// ===== rtl/ebma_in_if.sv =====
interface ebma_in_if;
  import ebma_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ===== rtl/ebma_out_if.sv =====
interface ebma_out_if;
  import ebma_pkg::*;

  logic    valid;
  logic    ready;
  sample_t filtered;
  logic    error_pass;

  modport source (output valid, output filtered, output error_pass, input ready);
  modport sink (input valid, input filtered, input error_pass, output ready);
endinterface

// ===== rtl/ebma_out_fifo.sv =====
module ebma_out_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ebma_pkg::fifo_ctrl_t ctrl,
  input  ebma_pkg::result_t    wr_data,
  output ebma_pkg::result_t    rd_data,
  output logic                 not_empty
);
  import ebma_pkg::*;

  result_t               q_mem [OUT_FIFO_DEPTH];
  logic [OUT_PTR_W-1:0]  wr_ptr_r;
  logic [OUT_PTR_W-1:0]  rd_ptr_r;
  logic [OCC_W-1:0]      count_r;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      q_mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (ctrl.wr_en) begin
        wr_ptr_r <= (wr_ptr_r == OUT_PTR_W'(OUT_FIFO_DEPTH - 1)) ? '0
                                                                  : wr_ptr_r + OUT_PTR_W'(1);
      end
      if (ctrl.rd_en) begin
        rd_ptr_r <= (rd_ptr_r == OUT_PTR_W'(OUT_FIFO_DEPTH - 1)) ? '0
                                                                  : rd_ptr_r + OUT_PTR_W'(1);
      end
      case ({ctrl.wr_en, ctrl.rd_en})
        2'b10:   count_r <= count_r + OCC_W'(1);
        2'b01:   count_r <= count_r - OCC_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign rd_data   = q_mem[rd_ptr_r];
  assign not_empty = (count_r != '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wr_en && !ctrl.rd_en |-> count_r != OCC_W'(OUT_FIFO_DEPTH))
    else $error("output queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.rd_en |-> count_r != '0)
    else $error("output queue read while empty");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wr_en && ctrl.rd_en |=> $stable(count_r))
    else $error("queue count moved on a simultaneous write and read");

endmodule

// ===== rtl/error_bypass_moving_average.sv =====
// Moving-average filter for a stream of signed Q12.4 temperature samples.
// Each transfer on in_ch carries one sample and produces exactly one transfer
// on out_ch, in order. A sample at or above the error threshold is passed
// through unchanged with error_pass set, and empties the window. The next good
// sample refills the whole window; later samples replace the oldest entry.
// The result is the window mean, or (mean + 5.0) / 10 when scale_mode is set.
// Configuration (cfg_we, cfg_index, cfg_data) must be written only while no
// sample is in flight; the block does not enforce this. Index 0 is the error
// threshold, index 1 the scale mode. Throughput is one sample per cycle while
// in_ch.ready is high. The window lives in a one-port-write, registered-read
// memory that is read and written at the same slot in the accept cycle, so the
// running sum is updated in the following cycle. Each sample passes through
// the memory read, sum update and divide-by-ten multiply in turn; results
// queue in a four-entry output FIFO. in_ch.ready drops only when four samples
// are outstanding, so a stalled receiver fills the queue and then holds off
// the sender. Synchronous reset empties the window, the queue and the pipeline
// and sets the threshold to 1000.0 degrees and the scale mode to off.
module error_bypass_moving_average (
  input  logic                        clk,
  input  logic                        rst_n,
  ebma_in_if.sink                     in_ch,
  ebma_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [ebma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ebma_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ebma_pkg::*;

  // Configuration registers.
  sample_t thresh_r;
  logic    scale_r;

  // Window state. The memory has no reset: a slot whose fresh bit is clear
  // holds the value of the last refill, which is kept in fill_val_r.
  sample_t               win_mem [WIN_DEPTH];
  sample_t               rd_data_r;
  logic [WIN_DEPTH-1:0]  fresh_r;
  sample_t               fill_val_r;
  logic                  full_r;
  logic                  full_nxt;
  slot_t                 slot_r;
  slot_t                 slot_nxt;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;

  // Accept stage.
  logic acc;
  logic is_err;
  logic is_fill;
  logic is_upd;

  // Stage after the memory read.
  logic    a_valid_r;
  logic    a_err_r;
  logic    a_fill_r;
  logic    a_fresh_r;
  sample_t a_sample_r;
  sample_t a_fill_val_r;
  sample_t old_val;
  sample_t mean;
  logic signed [SCALED_W-1:0] scaled_in;

  // Stage after the sum update.
  logic                b_valid_r;
  logic                b_err_r;
  logic                b_scale_r;
  logic                b_neg_r;
  sample_t             b_val_r;
  logic [SAMPLE_W-1:0] b_abs_r;

  // Divide-by-ten stage feeding the output queue.
  logic [PROD_W-1:0]   prod;
  logic [SAMPLE_W-1:0] quot;
  result_t             c_result;
  result_t             q_head;
  fifo_ctrl_t          fifo_ctrl;
  logic                q_not_empty;

  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] occ_nxt;
  logic             out_xfer;

  // ---------------------------------------------------------------------------
  // Configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
      scale_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ERR_THRESH: thresh_r <= sample_t'(cfg_data);
        CFG_SCALE_MODE: scale_r  <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Accept stage: classify the sample, step the window control and access the
  // memory at the current slot. The read returns the value being replaced.
  assign acc     = in_ch.valid && in_ch.ready;
  assign is_err  = in_ch.sample >= thresh_r;
  assign is_fill = !is_err && !full_r;
  assign is_upd  = !is_err && full_r;

  always_comb begin
    full_nxt = full_r;
    slot_nxt = slot_r;
    if (acc) begin
      full_nxt = !is_err;
      if (is_upd) begin
        slot_nxt = slot_r + slot_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_data_r <= win_mem[slot_r];
    end
    if (acc && is_upd) begin
      win_mem[slot_r] <= in_ch.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r  <= 1'b0;
      slot_r  <= '0;
      fresh_r <= '0;
    end else begin
      full_r <= full_nxt;
      slot_r <= slot_nxt;
      if (acc && is_fill) begin
        fresh_r <= '0;
      end else if (acc && is_upd) begin
        fresh_r[slot_r] <= 1'b1;
      end
    end
  end

  // A refill marks every slot as holding the new sample without touching the
  // memory.
  always_ff @(posedge clk) begin
    if (acc && is_fill) begin
      fill_val_r <= in_ch.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_err_r      <= is_err;
      a_fill_r     <= is_fill;
      a_fresh_r    <= fresh_r[slot_r];
      a_sample_r   <= in_ch.sample;
      a_fill_val_r <= fill_val_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Sum stage: the running sum drops the replaced entry and adds the new one.
  // Consecutive samples touch different slots, so no forwarding is needed.
  assign old_val = a_fresh_r ? rd_data_r : a_fill_val_r;

  always_comb begin
    if (a_fill_r) begin
      sum_nxt = SUM_W'(a_sample_r) <<< WIN_SHIFT;
    end else begin
      sum_nxt = sum_r - SUM_W'(old_val) + SUM_W'(a_sample_r);
    end
  end

  // Arithmetic shift gives the floor of the mean.
  assign mean      = sum_nxt[SUM_W-1:WIN_SHIFT];
  assign scaled_in = SCALED_W'(mean) + FIVE_Q4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (a_valid_r && !a_err_r) begin
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid_r) begin
      b_err_r   <= a_err_r;
      b_scale_r <= scale_r && !a_err_r;
      b_val_r   <= a_err_r ? a_sample_r : mean;
      b_neg_r   <= scaled_in[SCALED_W-1];
      b_abs_r   <= scaled_in[SCALED_W-1] ? SAMPLE_W'(-scaled_in) : SAMPLE_W'(scaled_in);
    end
  end

  // ---------------------------------------------------------------------------
  // Scale stage: divide the magnitude by ten, then restore the sign so the
  // quotient truncates toward zero.
  assign prod = PROD_W'(b_abs_r) * PROD_W'(RECIP_TEN);
  assign quot = SAMPLE_W'(prod[PROD_W-1:RECIP_SHIFT]);

  always_comb begin
    c_result.error_pass = b_err_r;
    if (b_scale_r) begin
      c_result.filtered = b_neg_r ? sample_t'(-quot) : sample_t'(quot);
    end else begin
      c_result.filtered = b_val_r;
    end
  end

  assign out_xfer        = out_ch.valid && out_ch.ready;
  assign fifo_ctrl.wr_en = b_valid_r;
  assign fifo_ctrl.rd_en = out_xfer;

  ebma_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (fifo_ctrl),
    .wr_data   (c_result),
    .rd_data   (q_head),
    .not_empty (q_not_empty)
  );

  assign out_ch.valid      = q_not_empty;
  assign out_ch.filtered   = q_head.filtered;
  assign out_ch.error_pass = q_head.error_pass;

  // ---------------------------------------------------------------------------
  // Samples in flight or queued; the queue has room for every one of them.
  always_comb begin
    occ_nxt = occ_r;
    case ({acc, out_xfer})
      2'b10:   occ_nxt = occ_r + OCC_W'(1);
      2'b01:   occ_nxt = occ_r - OCC_W'(1);
      default: occ_nxt = occ_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  assign in_ch.ready = (occ_r < OCC_W'(OUT_FIFO_DEPTH));

  // ---------------------------------------------------------------------------
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(OUT_FIFO_DEPTH))
    else $error("more samples outstanding than the output queue holds");

  a_out_has_owner: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> occ_r != '0)
    else $error("result offered with no sample outstanding");

  a_fill_clears_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    acc && is_fill |=> fresh_r == '0 && full_r)
    else $error("refill did not reset the window slots");

  a_err_empties: assert property (@(posedge clk) disable iff (!rst_n)
    acc && is_err |=> !full_r && $stable(slot_r))
    else $error("error sample did not empty the window or moved the slot");

  a_err_keeps_sum: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && a_err_r |=> $stable(sum_r))
    else $error("error sample changed the running sum");

endmodule

// ===== tb/error_bypass_moving_average_tb.sv =====
`timescale 1ns / 100ps

module error_bypass_moving_average_tb;
  import ebma_pkg::*;

  // Register indexes that the block has no register behind. Writes to them
  // must leave the threshold and the scale mode untouched.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX_B = 2'd3;

  // Pipeline settling time, waited out once the last result is back and before
  // any register write or the end of the run.
  localparam int LATENCY_CYCLES = 4;

  // The slowest legal run has roughly 650 transfers, each waiting out at most
  // one of an 84 percent sender gap and an 84 percent receiver stall, so this
  // limit leaves a wide margin.
  localparam int CYCLE_LIMIT = 400000;

  // Length of the long receiver hold-off that fills the output queue.
  localparam int HOLD_CYCLES = 120;

  localparam int NUM_PHASES = 6;

  // The scoreboard keeps its own copy of the window and of the registers.
  // For each accepted sample it predicts the result and queues it. Each
  // result the block delivers is then checked against the oldest one.
  class filter_scoreboard;
    sample_t   window [WIN_DEPTH];
    bit        window_full;
    slot_t     write_slot;
    int        window_sum;
    sample_t   threshold;
    bit        scale_on;
    result_t   expected_q [$];
    int        error_count;

    function new();
      window_full = 1'b0;
      write_slot  = '0;
      window_sum  = 0;
      threshold   = THRESH_RESET;
      scale_on    = 1'b0;
      error_count = 0;
      foreach (window[i]) window[i] = '0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ERR_THRESH: threshold = data;
        CFG_SCALE_MODE: scale_on = data[0];
        default: ;
      endcase
    endfunction

    function void note_sample(sample_t s);
      result_t r;
      int mean;
      int scaled;
      if (s >= threshold) begin
        // An error code goes straight through and empties the window.
        window_full  = 1'b0;
        r.filtered   = s;
        r.error_pass = 1'b1;
      end else begin
        if (!window_full) begin
          foreach (window[i]) window[i] = s;
          window_sum  = int'(s) * WIN_DEPTH;
          window_full = 1'b1;
        end else begin
          window_sum         = window_sum - int'(window[write_slot]) + int'(s);
          window[write_slot] = s;
          write_slot         = write_slot + 1'b1;
        end
        // An arithmetic shift of the sum rounds the mean toward minus infinity.
        mean = window_sum >>> WIN_SHIFT;
        // Integer division truncates toward zero, as the scaled mode wants.
        scaled       = (mean + 80) / 10;
        r.filtered   = scale_on ? sample_t'(scaled) : sample_t'(mean);
        r.error_pass = 1'b0;
      end
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
    endtask

    task check_result(sample_t filtered, logic error_pass);
      result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("result filtered=%0d error_pass=%b with no sample outstanding",
                         filtered, error_pass));
      end else begin
        e = expected_q.pop_front();
        if (filtered !== e.filtered)
          report($sformatf("filtered got %0d, predicted %0d", filtered, e.filtered));
        if (error_pass !== e.error_pass)
          report($sformatf("error_pass got %b, predicted %b", error_pass, e.error_pass));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ebma_in_if  in_ch ();
  ebma_out_if out_ch ();

  error_bypass_moving_average dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  filter_scoreboard sb = new();

  // Idling knobs, in percent of cycles. The main sequence sets them per phase.
  int send_idle_pct;
  int recv_stall_pct;

  // The main sequence asks for a hold-off by bumping hold_requests. The
  // receiver process owns the countdown, so the hold runs its full length no
  // matter what the sender is doing meanwhile.
  int hold_requests;
  int holds_taken;
  int hold_left;
  int cycle_count;

  // Per-phase settings for the random part: threshold, scale mode, idling,
  // hold-off and length. The threshold runs through both extremes and a few
  // values in between. The all-error phase is kept short.
  sample_t phase_thresh [NUM_PHASES] = '{16'sd16000, 16'sd16000, 16'sd32767,
                                         16'sd0, -16'sd32768, 16'sd1600};
  bit      phase_scale  [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  int      phase_sidle  [NUM_PHASES] = '{0, 84, 0, 7, 0, 0};
  int      phase_rstall [NUM_PHASES] = '{0, 0, 84, 7, 0, 84};
  bit      phase_hold   [NUM_PHASES] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
  int      phase_items  [NUM_PHASES] = '{120, 110, 110, 110, 40, 120};

  // Free-running clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog. It stops a run that hangs on a handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver. It either serves a pending hold-off or stalls at random.
  always @(posedge clk) begin
    if (hold_requests != holds_taken) begin
      holds_taken = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Output monitor. Signals are sampled at the edge, before the values
  // scheduled in this time step take effect, so what it reads is the state
  // that the transfer saw.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.filtered, out_ch.error_pass);
  end

  // Offers one sample, with an optional random gap before it, and returns at
  // the edge where the transfer happens. Valid stays high afterward. The
  // next call or the caller decides in that same step whether it drops.
  task send_sample(sample_t s);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(s);
  endtask

  task stop_sending();
    in_ch.valid <= 1'b0;
  endtask

  // Waits until every predicted result has come back. Then it lets the
  // pipeline settle, so that a register write cannot overtake a sample.
  task wait_idle();
    while (sb.pending() > 0) @(posedge clk);
    repeat (LATENCY_CYCLES) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.set_register(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // The random mix is mostly ordinary temperatures below the threshold, so
  // that the window keeps running for long stretches. Error codes are rare,
  // and each one forces a refill afterward. Some full-range values make
  // every bit of the sample toggle.
  function sample_t random_sample(sample_t thr);
    int pick;
    int lo;
    int t;
    pick = $urandom_range(99);
    lo   = thr;
    if (pick < 4) begin
      return sample_t'(int'($urandom_range(32767 - lo)) + lo);
    end else if (pick < 12) begin
      return sample_t'($urandom);
    end else begin
      t = int'($urandom_range(3200)) - 1600;
      if (t >= lo) begin
        t = lo - 1 - int'($urandom_range(63));
        if (t < -32768) t = -32768;
      end
      return sample_t'(t);
    end
  endfunction

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_ERR_THRESH;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.sample   = '0;
    out_ch.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests  = 0;
    holds_taken    = 0;
    hold_left      = 0;
    cycle_count    = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, at the reset settings: threshold 1000.0 degrees and
    // the plain mean. The first sample fills the window. A value just below
    // the threshold is kept, and one exactly at it is an error. Every error
    // is followed by a refill, and 15999 entering a window of -32768 checks that
    // the mean is rounded toward minus infinity.
    send_sample(16'sd0);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(-16'sd32768);
    send_sample(16'sd15999);
    send_sample(16'sd16000);
    send_sample(16'sd100);
    send_sample(-16'sd1);
    send_sample(-16'sd2);
    send_sample(16'sd1);
    stop_sending();
    wait_idle();

    // Scaled mode. The writes to the spare indexes must change nothing.
    write_reg(CFG_SCALE_MODE, 16'h0001);
    write_reg(CFG_SPARE_IDX_A, 16'hFFFF);
    write_reg(CFG_SPARE_IDX_B, 16'h0000);
    // The most negative window, then refills whose scaled results land on
    // both sides of zero, where truncation toward zero matters.
    send_sample(-16'sd32768);
    send_sample(-16'sd32768);
    send_sample(-16'sd32768);
    send_sample(16'sd20000);
    send_sample(-16'sd95);
    send_sample(16'sd16001);
    send_sample(16'sd15999);
    send_sample(16'sd16000);
    send_sample(-16'sd85);
    stop_sending();
    wait_idle();

    // Lowest threshold: every sample is an error, the most negative one too.
    write_reg(CFG_ERR_THRESH, 16'h8000);
    send_sample(-16'sd32768);
    send_sample(16'sd0);
    stop_sending();
    wait_idle();

    // Highest threshold: only the largest sample is an error.
    write_reg(CFG_ERR_THRESH, 16'h7FFF);
    send_sample(16'sd32767);
    send_sample(16'sd32766);
    send_sample(16'sd0);
    stop_sending();
    wait_idle();

    // Random part. Each phase sets the registers while the block is idle,
    // picks an idling mode and, in some phases, a long receiver hold-off
    // that fills the output queue while the sender keeps offering.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_ERR_THRESH, phase_thresh[p]);
      write_reg(CFG_SCALE_MODE, {15'd0, phase_scale[p]});
      send_idle_pct  = phase_sidle[p];
      recv_stall_pct = phase_rstall[p];
      if (phase_hold[p]) hold_requests <= hold_requests + 1;
      for (int n = 0; n < phase_items[p]; n++)
        send_sample(random_sample(sb.threshold));
      stop_sending();
      wait_idle();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_idle();
    repeat (LATENCY_CYCLES) @(posedge clk);

    if (sb.pending() > 0)
      sb.report($sformatf("%0d predicted results never arrived", sb.pending()));

    if (sb.error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ebma_pkg.sv
rtl/ebma_in_if.sv
rtl/ebma_out_if.sv
rtl/ebma_out_fifo.sv
rtl/error_bypass_moving_average.sv
tb/error_bypass_moving_average_tb.sv
